// ----- hw/rtl/xafu_pkg.sv -----
// x86 alu and flags unit: shared types, operation codes and flag bit positions
// no dependencies; used by the interfaces, the top level and the checker
package xafu_pkg;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned COUNT_W = 5;

  // flag bit positions in the flags word
  localparam int unsigned FLAG_CF  = 0;
  localparam int unsigned FLAG_ONE = 1;
  localparam int unsigned FLAG_PF  = 2;
  localparam int unsigned FLAG_AF  = 4;
  localparam int unsigned FLAG_ZF  = 6;
  localparam int unsigned FLAG_SF  = 7;
  localparam int unsigned FLAG_OF  = 11;

  localparam logic [DATA_W-1:0] FLAGS_RESET    = 16'h0002;
  localparam logic [DATA_W-1:0] FLAGS_SIX_MASK = 16'h08D5;
  localparam logic [DATA_W-1:0] FLAGS_CF_MASK  = 16'h0001;
  localparam logic [DATA_W-1:0] FLAGS_ONE_MASK = 16'h0002;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALU    = 3'd0,
    KIND_INCDEC = 3'd1,
    KIND_SHIFT  = 3'd2,
    KIND_COND   = 3'd3,
    KIND_LOAD   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_OR  = 3'd1,
    ALU_ADC = 3'd2,
    ALU_SBB = 3'd3,
    ALU_AND = 3'd4,
    ALU_SUB = 3'd5,
    ALU_XOR = 3'd6,
    ALU_CMP = 3'd7
  } alu_op_e;

  typedef enum logic [2:0] {
    SH_ROL = 3'd0,
    SH_ROR = 3'd1,
    SH_RCL = 3'd2,
    SH_RCR = 3'd3,
    SH_SHL = 3'd4,
    SH_SHR = 3'd5,
    SH_SAL = 3'd6,
    SH_SAR = 3'd7
  } shift_op_e;

  // condition pairs, selected by op[3:1]; op[0] inverts
  typedef enum logic [2:0] {
    COND_O  = 3'd0,
    COND_B  = 3'd1,
    COND_Z  = 3'd2,
    COND_BE = 3'd3,
    COND_S  = 3'd4,
    COND_P  = 3'd5,
    COND_L  = 3'd6,
    COND_LE = 3'd7
  } cond_e;

endpackage

// ----- hw/rtl/xafu_if.sv -----
// handshake channels of the x86 alu and flags unit: operation in, result out
// depends on xafu_pkg
interface xafu_in_if;
  logic                             valid;
  logic                             ready;
  logic [xafu_pkg::KIND_W-1:0]      kind;
  logic [xafu_pkg::OP_W-1:0]        op;
  logic                             wide;
  logic [xafu_pkg::DATA_W-1:0]      left_value;
  logic [xafu_pkg::DATA_W-1:0]      right_value;

  modport source (output valid, kind, op, wide, left_value, right_value, input ready);
  modport sink   (input valid, kind, op, wide, left_value, right_value, output ready);
endinterface

interface xafu_out_if;
  logic                             valid;
  logic                             ready;
  logic [xafu_pkg::DATA_W-1:0]      result;
  logic [xafu_pkg::DATA_W-1:0]      flags_out;
  logic                             condition_met;

  modport source (output valid, result, flags_out, condition_met, input ready);
  modport sink   (input valid, result, flags_out, condition_met, output ready);
endinterface

// ----- hw/rtl/x86_alu_flags_unit_top.sv -----
// x86 16-bit alu, inc/dec, shift/rotate, condition test and flags load
// depends on xafu_pkg and the channel interfaces in xafu_if.sv
//
//  channel | dir | payload                                      | handshake
//  in_i    | in  | kind, op, wide, left_value, right_value      | valid/ready
//  out_o   | out | result, flags_out, condition_met             | valid/ready
//
// one item per cycle while out_o is not stalled; an accepted item shows on out_o
// when it moves from the input register into the result register
// the flags register is updated as an item moves into the result register, so
// the next item already sees it
// reset clears both valid bits and sets the flags word to 0x0002
// a stalled output holds its item; the input register keeps taking items while
// the output is free or is being taken
module x86_alu_flags_unit_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  xafu_in_if.sink          in_i,
  xafu_out_if.source       out_o
);

  localparam int unsigned W = xafu_pkg::DATA_W;

  // input register
  logic                           in_valid_q;
  logic [xafu_pkg::KIND_W-1:0]    in_kind_q;
  logic [xafu_pkg::OP_W-1:0]      in_op_q;
  logic                           in_wide_q;
  logic [W-1:0]                   in_left_q;
  logic [W-1:0]                   in_right_q;

  // result register and flags
  logic                           out_valid_q;
  logic [W-1:0]                   out_result_q, out_result_d;
  logic [W-1:0]                   out_flags_q;
  logic                           out_met_q, out_met_d;
  logic [W-1:0]                   flags_q, flags_d;

  logic advance;
  logic in_take;

  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_take = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_kind_q  <= in_i.kind;
      in_op_q    <= in_i.op;
      in_wide_q  <= in_i.wide;
      in_left_q  <= in_i.left_value;
      in_right_q <= in_i.right_value;
    end
  end

  // zero, sign and parity flags of a masked value
  function automatic logic [W-1:0] zsp_flags(input logic [W-1:0] v, input logic wide);
    logic [W-1:0] f;
    f = '0;
    f[xafu_pkg::FLAG_ZF] = (v == '0);
    f[xafu_pkg::FLAG_SF] = wide ? v[W-1] : v[7];
    f[xafu_pkg::FLAG_PF] = ~(^v[7:0]);
    return f;
  endfunction

  // operands masked to the operand width
  logic [W-1:0] opl, opr;
  logic         cf;
  assign opl = in_wide_q ? in_left_q  : {8'b0, in_left_q[7:0]};
  assign opr = in_wide_q ? in_right_q : {8'b0, in_right_q[7:0]};
  assign cf  = flags_q[xafu_pkg::FLAG_CF];

  // ---------------- add/sub/logic path (also inc/dec) ----------------
  xafu_pkg::alu_op_e alu_op;
  logic [W-1:0]      alu_arg;
  logic              cin;
  logic [W:0]        sum, diff;
  logic [W-1:0]      alu_v, alu_f;
  logic              is_sub;

  always_comb begin
    if (in_kind_q == xafu_pkg::KIND_INCDEC) begin
      alu_op  = in_op_q[0] ? xafu_pkg::ALU_SUB : xafu_pkg::ALU_ADD;
      alu_arg = W'(1);
    end else begin
      alu_op  = xafu_pkg::alu_op_e'(in_op_q[2:0]);
      alu_arg = opr;
    end
    cin  = ((alu_op == xafu_pkg::ALU_ADC) || (alu_op == xafu_pkg::ALU_SBB)) ? cf : 1'b0;
    sum  = {1'b0, opl} + {1'b0, alu_arg} + (W+1)'(cin);
    diff = {1'b0, opl} - {1'b0, alu_arg} - (W+1)'(cin);
    is_sub = 1'b0;
    alu_f  = '0;
    unique case (alu_op)
      xafu_pkg::ALU_OR:  alu_v = opl | alu_arg;
      xafu_pkg::ALU_AND: alu_v = opl & alu_arg;
      xafu_pkg::ALU_XOR: alu_v = opl ^ alu_arg;
      xafu_pkg::ALU_ADD, xafu_pkg::ALU_ADC: begin
        alu_v = in_wide_q ? sum[W-1:0] : {8'b0, sum[7:0]};
        alu_f[xafu_pkg::FLAG_CF] = in_wide_q ? sum[W] : sum[8];
      end
      default: begin
        // sub, sbb, cmp: borrow out of the zero-extended difference
        is_sub = 1'b1;
        alu_v = in_wide_q ? diff[W-1:0] : {8'b0, diff[7:0]};
        alu_f[xafu_pkg::FLAG_CF] = diff[W];
      end
    endcase
    if (alu_op != xafu_pkg::ALU_OR && alu_op != xafu_pkg::ALU_AND &&
        alu_op != xafu_pkg::ALU_XOR) begin
      if (is_sub) begin
        alu_f[xafu_pkg::FLAG_OF] = in_wide_q
          ? ((opl[W-1] ^ alu_arg[W-1]) & (opl[W-1] ^ alu_v[W-1]))
          : ((opl[7] ^ alu_arg[7]) & (opl[7] ^ alu_v[7]));
      end else begin
        alu_f[xafu_pkg::FLAG_OF] = in_wide_q
          ? (~(opl[W-1] ^ alu_arg[W-1]) & (opl[W-1] ^ alu_v[W-1]))
          : (~(opl[7] ^ alu_arg[7]) & (opl[7] ^ alu_v[7]));
      end
      alu_f[xafu_pkg::FLAG_AF] = opl[4] ^ alu_arg[4] ^ alu_v[4];
    end
    alu_f = alu_f | zsp_flags(alu_v, in_wide_q);
  end

  // ---------------- shift/rotate path ----------------
  xafu_pkg::shift_op_e          sh_op;
  logic [xafu_pkg::COUNT_W-1:0] cnt, cnt_m1, t18;
  logic [xafu_pkg::COUNT_W-1:0] b17, b9;
  logic [3:0]                   rb;
  logic [2*W-1:0]               dw;
  logic [15:0]                  db;
  logic [2*W+1:0]               x34;
  logic [17:0]                  x18;
  logic [2*W-1:0]               w32, s32, sr32, sr32_m1;
  logic [W-1:0]                 shr_m1;
  logic [W-1:0]                 sh_v;
  logic                         sh_c;

  always_comb begin
    sh_op  = xafu_pkg::shift_op_e'(in_op_q[2:0]);
    cnt    = in_right_q[xafu_pkg::COUNT_W-1:0];
    cnt_m1 = cnt - xafu_pkg::COUNT_W'(1);
    // count mod 17 and mod 9 for rotates through carry
    b17 = (cnt >= xafu_pkg::COUNT_W'(17)) ? cnt - xafu_pkg::COUNT_W'(17) : cnt;
    t18 = (cnt >= xafu_pkg::COUNT_W'(18)) ? cnt - xafu_pkg::COUNT_W'(18) : cnt;
    b9  = (t18 >= xafu_pkg::COUNT_W'(9)) ? t18 - xafu_pkg::COUNT_W'(9) : t18;
    rb  = in_wide_q ? cnt[3:0] : {1'b0, cnt[2:0]};
    dw  = '0;
    db  = '0;
    x34 = '0;
    x18 = '0;
    s32 = in_wide_q ? {{W{opl[W-1]}}, opl} : {{(2*W-8){opl[7]}}, opl[7:0]};
    w32 = {{W{1'b0}}, opl} << cnt;
    sr32    = $unsigned($signed(s32) >>> cnt);
    sr32_m1 = $unsigned($signed(s32) >>> cnt_m1);
    shr_m1  = opl >> cnt_m1;
    sh_v = opl;
    sh_c = cf;
    unique case (sh_op)
      xafu_pkg::SH_ROL: begin
        if (in_wide_q) begin
          dw   = {opl, opl} << rb;
          sh_v = dw[2*W-1:W];
          sh_c = dw[W];
        end else begin
          db   = {opl[7:0], opl[7:0]} << rb;
          sh_v = {8'b0, db[15:8]};
          sh_c = db[8];
        end
      end
      xafu_pkg::SH_ROR: begin
        if (in_wide_q) begin
          dw   = {opl, opl} >> rb;
          sh_v = dw[W-1:0];
          sh_c = dw[W-1];
        end else begin
          db   = {opl[7:0], opl[7:0]} >> rb;
          sh_v = {8'b0, db[7:0]};
          sh_c = db[7];
        end
      end
      xafu_pkg::SH_RCL: begin
        if (in_wide_q) begin
          x34  = {cf, opl, cf, opl} << b17;
          sh_v = x34[2*W:W+1];
          sh_c = x34[2*W+1];
        end else begin
          x18  = {cf, opl[7:0], cf, opl[7:0]} << b9;
          sh_v = {8'b0, x18[16:9]};
          sh_c = x18[17];
        end
      end
      xafu_pkg::SH_RCR: begin
        if (in_wide_q) begin
          x34  = {cf, opl, cf, opl} >> b17;
          sh_v = x34[W-1:0];
          sh_c = x34[W];
        end else begin
          x18  = {cf, opl[7:0], cf, opl[7:0]} >> b9;
          sh_v = {8'b0, x18[7:0]};
          sh_c = x18[8];
        end
      end
      xafu_pkg::SH_SHL, xafu_pkg::SH_SAL: begin
        sh_v = in_wide_q ? w32[W-1:0] : {8'b0, w32[7:0]};
        sh_c = in_wide_q ? w32[W] : w32[8];
      end
      xafu_pkg::SH_SHR: begin
        sh_v = opl >> cnt;
        sh_c = shr_m1[0];
      end
      xafu_pkg::SH_SAR: begin
        sh_v = in_wide_q ? sr32[W-1:0] : {8'b0, sr32[7:0]};
        sh_c = sr32_m1[0];
      end
      default: begin
        sh_v = opl;
        sh_c = cf;
      end
    endcase
  end

  // ---------------- condition test ----------------
  logic cond_t;
  always_comb begin
    unique case (xafu_pkg::cond_e'(in_op_q[3:1]))
      xafu_pkg::COND_O:  cond_t = flags_q[xafu_pkg::FLAG_OF];
      xafu_pkg::COND_B:  cond_t = flags_q[xafu_pkg::FLAG_CF];
      xafu_pkg::COND_Z:  cond_t = flags_q[xafu_pkg::FLAG_ZF];
      xafu_pkg::COND_BE: cond_t = flags_q[xafu_pkg::FLAG_CF] | flags_q[xafu_pkg::FLAG_ZF];
      xafu_pkg::COND_S:  cond_t = flags_q[xafu_pkg::FLAG_SF];
      xafu_pkg::COND_P:  cond_t = flags_q[xafu_pkg::FLAG_PF];
      xafu_pkg::COND_L:  cond_t = flags_q[xafu_pkg::FLAG_SF] ^ flags_q[xafu_pkg::FLAG_OF];
      xafu_pkg::COND_LE: cond_t = flags_q[xafu_pkg::FLAG_ZF] |
                                  (flags_q[xafu_pkg::FLAG_SF] ^ flags_q[xafu_pkg::FLAG_OF]);
      default:           cond_t = 1'b0;
    endcase
  end

  // ---------------- result select ----------------
  always_comb begin
    out_result_d = '0;
    out_met_d    = 1'b0;
    flags_d      = flags_q;
    unique case (in_kind_q)
      xafu_pkg::KIND_ALU: begin
        out_result_d = alu_v;
        flags_d      = (flags_q & ~xafu_pkg::FLAGS_SIX_MASK) | alu_f;
      end
      xafu_pkg::KIND_INCDEC: begin
        // carry is kept
        out_result_d = alu_v;
        flags_d      = (flags_q & ~xafu_pkg::FLAGS_SIX_MASK) |
                       (alu_f & ~xafu_pkg::FLAGS_CF_MASK) |
                       (flags_q & xafu_pkg::FLAGS_CF_MASK);
      end
      xafu_pkg::KIND_SHIFT: begin
        if (cnt == '0) begin
          out_result_d = opl;
        end else begin
          out_result_d = sh_v;
          if (in_op_q[2]) begin
            flags_d = (flags_q & ~xafu_pkg::FLAGS_SIX_MASK) |
                      zsp_flags(sh_v, in_wide_q) | W'(sh_c);
          end else begin
            flags_d = (flags_q & ~xafu_pkg::FLAGS_CF_MASK) | W'(sh_c);
          end
        end
      end
      xafu_pkg::KIND_COND: out_met_d = cond_t ^ in_op_q[0];
      xafu_pkg::KIND_LOAD: flags_d   = in_right_q;
      default: ;
    endcase
    flags_d = flags_d | xafu_pkg::FLAGS_ONE_MASK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      flags_q     <= xafu_pkg::FLAGS_RESET;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        flags_q     <= flags_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_result_q <= out_result_d;
      out_flags_q  <= flags_d;
      out_met_q    <= out_met_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result        = out_result_q;
  assign out_o.flags_out     = out_flags_q;
  assign out_o.condition_met = out_met_q;

endmodule

// ----- hw/rtl/xafu_checker.sv -----
// port-level checks for the x86 alu and flags unit, bound to the top level
// depends on xafu_pkg and x86_alu_flags_unit_top
module xafu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [xafu_pkg::DATA_W-1:0]  out_result_i,
  input logic [xafu_pkg::DATA_W-1:0]  out_flags_i,
  input logic                         out_met_i
);

  // no item shows while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // the fixed flags bit is set in every item
  a_flag_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_flags_i[xafu_pkg::FLAG_ONE])
    else $error("flags bit 1 clear");

  // a condition test that holds carries a zero result
  a_met_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_met_i) |-> (out_result_i == '0))
    else $error("condition met with nonzero result");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_result_i) && $stable(out_flags_i) && $stable(out_met_i)))
    else $error("stalled item changed");

  // input side never refuses while nothing is held in the unit
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i && !$past(in_valid_i)) |-> in_ready_i)
    else $error("input not ready while empty");

endmodule

bind x86_alu_flags_unit_top xafu_checker u_xafu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_result_i (out_o.result),
  .out_flags_i  (out_o.flags_out),
  .out_met_i    (out_o.condition_met)
);

// ----- sim/x86_alu_flags_unit_top_tb.sv -----
// testbench for x86_alu_flags_unit_top: directed and random operations with random idling
// a local flags model predicts every result item; uses xafu_pkg, xafu_if.sv and the unit
module x86_alu_flags_unit_top_tb;

  typedef struct packed {
    logic [xafu_pkg::KIND_W-1:0] kind;
    logic [xafu_pkg::OP_W-1:0]   op;
    logic                        wide;
    logic [xafu_pkg::DATA_W-1:0] left_value;
    logic [xafu_pkg::DATA_W-1:0] right_value;
  } op_item_t;

  typedef struct packed {
    logic [xafu_pkg::DATA_W-1:0] result;
    logic [xafu_pkg::DATA_W-1:0] flags_out;
    logic                        condition_met;
  } res_item_t;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 8;
  localparam int unsigned RANDOM_OPS   = 1200;
  localparam int unsigned PHASE_LEN    = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned MAX_REPORTS  = 100;
  localparam int unsigned DW           = xafu_pkg::DATA_W;
  // largest kind code; codes above KIND_LOAD are ignored by the unit
  localparam logic [xafu_pkg::KIND_W-1:0] KIND_LAST = 3'd7;

  // idle and stall percentages per phase: none, sender, receiver, both
  localparam int unsigned SEND_IDLE[4]  = '{0, 54, 0, 13};
  localparam int unsigned RECV_STALL[4] = '{0, 0, 54, 13};

  localparam logic [DW-1:0] CORNERS[8] = '{16'h0000, 16'h0001, 16'h007f, 16'h0080,
                                           16'h00ff, 16'h7fff, 16'h8000, 16'hffff};

  logic clk_i = 1'b0;
  logic rst_ni;

  xafu_in_if  in_if ();
  xafu_out_if out_if ();

  x86_alu_flags_unit_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  op_item_t          op_queue[$];
  res_item_t         exp_results[$];
  logic [DW-1:0]     model_flags;
  int unsigned       sent_cnt  = 0;
  int unsigned       cycle_cnt = 0;
  int unsigned       errors    = 0;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  function automatic int unsigned phase();
    return (sent_cnt / PHASE_LEN) % 4;
  endfunction

  function automatic logic [DW-1:0] szp_bits(logic [31:0] v, logic [31:0] sign);
    logic [DW-1:0] f;
    f = '0;
    f[xafu_pkg::FLAG_ZF] = (v == 0);
    f[xafu_pkg::FLAG_SF] = ((v & sign) != 0);
    f[xafu_pkg::FLAG_PF] = ~^v[7:0];
    return f;
  endfunction

  function automatic logic [31:0] arith_logic(xafu_pkg::alu_op_e opc, logic [31:0] l,
                                              logic [31:0] q, logic [31:0] mask);
    logic [31:0]   sign, v, s, c, half;
    logic [DW-1:0] f;
    sign = (mask + 1) >> 1;
    f = '0;
    c = 0;
    case (opc)
      xafu_pkg::ALU_OR:  v = (l | q) & mask;
      xafu_pkg::ALU_AND: v = (l & q) & mask;
      xafu_pkg::ALU_XOR: v = (l ^ q) & mask;
      default: begin
        if (opc == xafu_pkg::ALU_ADC || opc == xafu_pkg::ALU_SBB)
          c = {31'd0, model_flags[xafu_pkg::FLAG_CF]};
        if (opc == xafu_pkg::ALU_ADD || opc == xafu_pkg::ALU_ADC) begin
          s = l + q + c;
          v = s & mask;
          f[xafu_pkg::FLAG_CF] = (s > mask);
          f[xafu_pkg::FLAG_OF] = ((~(l ^ q) & (l ^ v) & sign) != 0);
        end else begin
          v = (l - q - c) & mask;
          f[xafu_pkg::FLAG_CF] = (l < q + c);
          f[xafu_pkg::FLAG_OF] = (((l ^ q) & (l ^ v) & sign) != 0);
        end
        // auxiliary carry is the carry into bit 4
        half = l ^ q ^ v;
        f[xafu_pkg::FLAG_AF] = half[xafu_pkg::FLAG_AF];
      end
    endcase
    f = f | szp_bits(v, sign);
    model_flags = (model_flags & ~xafu_pkg::FLAGS_SIX_MASK) | f | xafu_pkg::FLAGS_ONE_MASK;
    return v;
  endfunction

  function automatic logic [31:0] shift_rotate(xafu_pkg::shift_op_e opc, logic [31:0] v,
                                               int unsigned count, logic wide);
    int unsigned bits, b, i;
    logic [31:0] mask, sign, res, s, carry, nx;
    logic        neg;
    bits  = wide ? 16 : 8;
    mask  = wide ? 32'hffff : 32'h00ff;
    sign  = (mask + 1) >> 1;
    carry = {31'd0, model_flags[xafu_pkg::FLAG_CF]};
    res   = v;
    if (count == 0) return v;
    case (opc)
      xafu_pkg::SH_ROL: begin
        b = count % bits;
        if (b != 0) res = ((v << b) | (v >> (bits - b))) & mask;
        carry = res & 1;
      end
      xafu_pkg::SH_ROR: begin
        b = count % bits;
        if (b != 0) res = ((v >> b) | (v << (bits - b))) & mask;
        carry = (res >> (bits - 1)) & 1;
      end
      xafu_pkg::SH_RCL: begin
        b = count % (bits + 1);
        for (i = 0; i < b; i++) begin
          nx = (res >> (bits - 1)) & 1;
          res = ((res << 1) | carry) & mask;
          carry = nx;
        end
      end
      xafu_pkg::SH_RCR: begin
        b = count % (bits + 1);
        for (i = 0; i < b; i++) begin
          nx = res & 1;
          res = (res >> 1) | (carry << (bits - 1));
          carry = nx;
        end
      end
      xafu_pkg::SH_SHL, xafu_pkg::SH_SAL: begin
        carry = (count <= bits) ? ((v >> (bits - count)) & 1) : 0;
        res = (v << count) & mask;
      end
      xafu_pkg::SH_SHR: begin
        carry = (count <= bits) ? ((v >> (count - 1)) & 1) : 0;
        res = v >> count;
      end
      default: begin
        neg = ((v & sign) != 0);
        s = neg ? (v | ~mask) : v;
        carry = (count <= bits) ? ((s >> (count - 1)) & 1) : {31'd0, neg};
        res = (neg ? ~((~s) >> count) : (s >> count)) & mask;
      end
    endcase
    // rotates touch only carry; plain shifts rebuild sign/zero/parity and clear overflow and aux carry
    if (opc >= xafu_pkg::SH_SHL)
      model_flags = (model_flags & ~xafu_pkg::FLAGS_SIX_MASK) | szp_bits(res, sign);
    model_flags = {model_flags[DW-1:1], carry[0]} | xafu_pkg::FLAGS_ONE_MASK;
    return res;
  endfunction

  function automatic logic cond_holds(logic [xafu_pkg::OP_W-1:0] code);
    logic t;
    case (xafu_pkg::cond_e'(code[3:1]))
      xafu_pkg::COND_O:  t = model_flags[xafu_pkg::FLAG_OF];
      xafu_pkg::COND_B:  t = model_flags[xafu_pkg::FLAG_CF];
      xafu_pkg::COND_Z:  t = model_flags[xafu_pkg::FLAG_ZF];
      xafu_pkg::COND_BE: t = model_flags[xafu_pkg::FLAG_CF] | model_flags[xafu_pkg::FLAG_ZF];
      xafu_pkg::COND_S:  t = model_flags[xafu_pkg::FLAG_SF];
      xafu_pkg::COND_P:  t = model_flags[xafu_pkg::FLAG_PF];
      xafu_pkg::COND_L:  t = model_flags[xafu_pkg::FLAG_SF] != model_flags[xafu_pkg::FLAG_OF];
      default: t = model_flags[xafu_pkg::FLAG_ZF] |
                   (model_flags[xafu_pkg::FLAG_SF] != model_flags[xafu_pkg::FLAG_OF]);
    endcase
    return code[0] ? !t : t;
  endfunction

  function automatic res_item_t alu_flags_predict(op_item_t it);
    logic [31:0] mask, l, r, res;
    logic        kept_cf, met;
    mask = it.wide ? 32'hffff : 32'h00ff;
    l    = {16'd0, it.left_value} & mask;
    r    = {16'd0, it.right_value};
    res  = 0;
    met  = 1'b0;
    case (it.kind)
      xafu_pkg::KIND_ALU:
        res = arith_logic(xafu_pkg::alu_op_e'(it.op[2:0]), l, r & mask, mask);
      xafu_pkg::KIND_INCDEC: begin
        kept_cf = model_flags[xafu_pkg::FLAG_CF];
        res = arith_logic(it.op[0] ? xafu_pkg::ALU_SUB : xafu_pkg::ALU_ADD, l, 32'd1, mask);
        model_flags[xafu_pkg::FLAG_CF] = kept_cf;
      end
      xafu_pkg::KIND_SHIFT:
        res = shift_rotate(xafu_pkg::shift_op_e'(it.op[2:0]), l,
                           32'(r[xafu_pkg::COUNT_W-1:0]), it.wide);
      xafu_pkg::KIND_COND: met = cond_holds(it.op);
      xafu_pkg::KIND_LOAD: model_flags = it.right_value | xafu_pkg::FLAGS_ONE_MASK;
      default: ;
    endcase
    return '{result: res[DW-1:0], flags_out: model_flags | xafu_pkg::FLAGS_ONE_MASK,
             condition_met: met};
  endfunction

  function automatic void queue_op(logic [xafu_pkg::KIND_W-1:0] kind,
                                   logic [xafu_pkg::OP_W-1:0] op, logic wide,
                                   logic [DW-1:0] l, logic [DW-1:0] r);
    op_queue.push_back('{kind: kind, op: op, wide: wide, left_value: l, right_value: r});
  endfunction

  function automatic logic [DW-1:0] pick_operand();
    if ($urandom_range(2) == 0) return CORNERS[$urandom_range(7)];
    return DW'($urandom);
  endfunction

  function automatic op_item_t random_op();
    op_item_t    it;
    int unsigned pick;
    pick           = $urandom_range(99);
    it.op          = xafu_pkg::OP_W'($urandom);
    it.wide        = 1'($urandom);
    it.left_value  = pick_operand();
    it.right_value = pick_operand();
    if (pick < 35) it.kind = xafu_pkg::KIND_ALU;
    else if (pick < 45) it.kind = xafu_pkg::KIND_INCDEC;
    else if (pick < 70) begin
      it.kind = xafu_pkg::KIND_SHIFT;
      // mostly counts around the operand widths
      if ($urandom_range(3) != 0)
        it.right_value[xafu_pkg::COUNT_W-1:0] = xafu_pkg::COUNT_W'($urandom_range(17));
    end
    else if (pick < 85) it.kind = xafu_pkg::KIND_COND;
    else if (pick < 95) it.kind = xafu_pkg::KIND_LOAD;
    else it.kind = xafu_pkg::KIND_W'($urandom_range(int'(KIND_LAST),
                                                    int'(xafu_pkg::KIND_LOAD) + 1));
    return it;
  endfunction

  task automatic check_field(string name, logic [DW-1:0] want, logic [DW-1:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // driver: predicts each accepted item, then offers the next pending one
  always @(posedge clk_i) begin
    op_item_t nxt;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        exp_results.push_back(alu_flags_predict('{kind: in_if.kind, op: in_if.op,
                                                  wide: in_if.wide,
                                                  left_value: in_if.left_value,
                                                  right_value: in_if.right_value}));
      if (!in_if.valid || in_if.ready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= SEND_IDLE[phase()]) begin
          nxt = op_queue.pop_front();
          in_if.valid       <= 1'b1;
          in_if.kind        <= nxt.kind;
          in_if.op          <= nxt.op;
          in_if.wide        <= nxt.wide;
          in_if.left_value  <= nxt.left_value;
          in_if.right_value <= nxt.right_value;
          sent_cnt++;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each taken result item with the oldest prediction
  always @(posedge clk_i) begin
    res_item_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (exp_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected item, expected none, actual result %h flags %h met %b",
                     $time, out_if.result, out_if.flags_out, out_if.condition_met);
        end else begin
          want = exp_results.pop_front();
          check_field("result", want.result, out_if.result);
          check_field("flags_out", want.flags_out, out_if.flags_out);
          check_field("condition_met", {15'd0, want.condition_met},
                      {15'd0, out_if.condition_met});
        end
      end
      out_if.ready <= ($urandom_range(99) >= RECV_STALL[phase()]);
    end
  end

  initial begin
    op_item_t    it;
    int unsigned n;
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.kind        = xafu_pkg::KIND_ALU;
    in_if.op          = '0;
    in_if.wide        = 1'b0;
    in_if.left_value  = '0;
    in_if.right_value = '0;
    out_if.ready      = 1'b0;
    model_flags       = xafu_pkg::FLAGS_RESET;

    // byte add ignores the upper operand bits and wraps to zero
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_ADD}, 1'b0, 16'h12ff, 16'h3401);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_ADD}, 1'b1, 16'h7fff, 16'h0001);
    queue_op(xafu_pkg::KIND_LOAD, '0, 1'b0, 16'h0000, 16'h0001);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_ADC}, 1'b1, 16'hffff, 16'hffff);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_SBB}, 1'b0, 16'h0000, 16'h00ff);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_OR}, 1'b1, 16'h8000, 16'h0001);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_AND}, 1'b0, 16'h00f0, 16'h000f);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_SUB}, 1'b0, 16'h0000, 16'h0001);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_XOR}, 1'b1, 16'hffff, 16'hffff);
    queue_op(xafu_pkg::KIND_ALU, {1'b0, xafu_pkg::ALU_CMP}, 1'b0, 16'h0080, 16'h0001);
    queue_op(xafu_pkg::KIND_ALU, {1'b1, xafu_pkg::ALU_SUB}, 1'b1, 16'h0000, 16'hffff);
    // inc keeps the carry left by the previous item
    queue_op(xafu_pkg::KIND_INCDEC, 4'd0, 1'b1, 16'hffff, 16'h0000);
    queue_op(xafu_pkg::KIND_INCDEC, 4'hf, 1'b0, 16'h0080, 16'h0000);
    // count bits above the low five are dropped, so this is a zero count
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_ROL}, 1'b1, 16'h1234, 16'hffe0);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_ROL}, 1'b0, 16'h0081, 16'h0008);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_RCL}, 1'b0, 16'h0080, 16'h0009);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_RCR}, 1'b1, 16'h0001, 16'h0011);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_SHL}, 1'b0, 16'h00ff, 16'h0009);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_SAL}, 1'b0, 16'h0081, 16'h0008);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_SHR}, 1'b1, 16'hffff, 16'h001f);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b0, xafu_pkg::SH_SAR}, 1'b0, 16'h0080, 16'h0014);
    queue_op(xafu_pkg::KIND_SHIFT, {1'b1, xafu_pkg::SH_SAR}, 1'b1, 16'h8001, 16'h0010);
    queue_op(xafu_pkg::KIND_LOAD, '0, 1'b0, 16'h0000, 16'hffff);
    queue_op(xafu_pkg::KIND_COND, {xafu_pkg::COND_LE, 1'b0}, 1'b0, 16'h0000, 16'h0000);
    queue_op(xafu_pkg::KIND_LOAD, '0, 1'b1, 16'hffff, 16'h0000);
    queue_op(xafu_pkg::KIND_COND, {xafu_pkg::COND_P, 1'b1}, 1'b1, 16'hffff, 16'hffff);
    queue_op(KIND_LAST, 4'hf, 1'b1, 16'hffff, 16'hffff);

    n = 0;
    while (n < RANDOM_OPS) begin
      it = random_op();
      op_queue.push_back(it);
      if (it.kind <= xafu_pkg::KIND_LOAD) n++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while ((op_queue.size() != 0 || in_if.valid || exp_results.size() != 0)
           && cycle_cnt < CYCLE_LIMIT)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (cycle_cnt >= CYCLE_LIMIT) begin
      errors++;
      $display("%0t: timeout after %0d cycles, %0d items still expected",
               $time, cycle_cnt, exp_results.size());
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- x86_alu_flags_unit_top.f -----
hw/rtl/xafu_pkg.sv
hw/rtl/xafu_if.sv
hw/rtl/x86_alu_flags_unit_top.sv
hw/rtl/xafu_checker.sv
sim/x86_alu_flags_unit_top_tb.sv
